@@ src/wtsp_pkg.sv @@
// Shared widths, register indexes and stage control type for the projection core.
// No dependencies; every other file imports it.
package wtsp_pkg;

   localparam int ACC_W = 66;   // exact sum of four 64-bit products
   localparam int DEN_W = 67;   // 2 * |w|
   localparam int NUM_W = 82;   // (w + c) * size + w, two's complement
   localparam int SIZE_W = 14;
   localparam int IDX_W = 4;
   localparam int OUT_W = 16;

   localparam logic [IDX_W-1:0] CSR_MAT_X_01 = 4'd0;
   localparam logic [IDX_W-1:0] CSR_MAT_X_23 = 4'd1;
   localparam logic [IDX_W-1:0] CSR_MAT_Y_01 = 4'd2;
   localparam logic [IDX_W-1:0] CSR_MAT_Y_23 = 4'd3;
   localparam logic [IDX_W-1:0] CSR_MAT_W_01 = 4'd4;
   localparam logic [IDX_W-1:0] CSR_MAT_W_23 = 4'd5;
   localparam logic [IDX_W-1:0] CSR_VIEW_WIDTH = 4'd6;
   localparam logic [IDX_W-1:0] CSR_VIEW_HEIGHT = 4'd7;

   typedef struct packed {
      logic valid;
      logic degen;
   } wtsp_ctl_type;

endpackage

@@ src/world_to_screen_projection_core.sv @@
// Channel | ports                                  | transfer when
// req     | start, busy, req_world_x/y/z           | start & !busy (busy stays low)
// rsp     | rsp_valid, rsp_screen_x/y, rsp_degenerate, rsp_clipped | rsp_valid, one cycle
// csr     | csr_valid, csr_ready, csr_index, csr_wdata | csr_valid & csr_ready
// One point per clock. A request passes the input register, the product and sum stages,
// the map stages, the one-bit-per-stage divider (PIXEL_WIDTH stages) and the output
// register before rsp_valid rises; the divider sets most of that path.
// Synchronous reset clears valid bits and loads the matrix and viewport defaults.
// Results cannot be held off; nothing in the pipe ever stalls.
// Top level: csr file, input and output registers, saturation. Uses wtsp_pkg,
// wtsp_dot, wtsp_map, wtsp_div.
module world_to_screen_projection_core #(
   parameter int FRAC_BITS = 16,
   parameter int PIXEL_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [31:0] req_world_x,
   input  logic signed [31:0] req_world_y,
   input  logic signed [31:0] req_world_z,
   output logic rsp_valid,
   output logic signed [wtsp_pkg::OUT_W-1:0] rsp_screen_x,
   output logic signed [wtsp_pkg::OUT_W-1:0] rsp_screen_y,
   output logic rsp_degenerate,
   output logic rsp_clipped,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [wtsp_pkg::IDX_W-1:0] csr_index,
   input  logic [63:0] csr_wdata
);
   import wtsp_pkg::*;

   localparam int LAT = PIXEL_WIDTH + 7;
   localparam logic [PIXEL_WIDTH-1:0] LIM_POS = PIXEL_WIDTH'((1 << (PIXEL_WIDTH-1)) - 1);
   localparam logic [PIXEL_WIDTH-1:0] LIM_NEG = PIXEL_WIDTH'(1 << (PIXEL_WIDTH-1));

   logic [5:0][63:0] mat_ff, mat_in;
   logic [SIZE_W-1:0] vw_ff, vw_in, vh_ff, vh_in;
   logic accept, v0_ff;
   logic signed [31:0] wx_ff, wy_ff, wz_ff;

   logic dot_valid;
   logic signed [ACC_W-1:0] acc_x, acc_y, acc_w;
   wtsp_ctl_type map_ctl, dx_ctl, dy_ctl;
   logic [NUM_W-1:0] num_x, num_y;
   logic neg_x, neg_y, dx_neg, dy_neg, dx_ovf, dy_ovf;
   logic [DEN_W-1:0] den;
   logic [PIXEL_WIDTH-1:0] dx_quo, dy_quo, qx, qy;
   logic sat_x, sat_y;
   logic [31:0] sx, sy;

   logic rv_ff, rdeg_ff, rclip_ff;
   logic [OUT_W-1:0] rx_ff, ry_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_comb begin
      mat_in = mat_ff;
      vw_in = vw_ff;
      vh_in = vh_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAT_X_01: mat_in[0] = csr_wdata;
            CSR_MAT_X_23: mat_in[1] = csr_wdata;
            CSR_MAT_Y_01: mat_in[2] = csr_wdata;
            CSR_MAT_Y_23: mat_in[3] = csr_wdata;
            CSR_MAT_W_01: mat_in[4] = csr_wdata;
            CSR_MAT_W_23: mat_in[5] = csr_wdata;
            CSR_VIEW_WIDTH: vw_in = csr_wdata[SIZE_W-1:0];
            CSR_VIEW_HEIGHT: vh_in = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[0] <= 64'h0000_0000_0001_0000 << 16;
         mat_ff[1] <= 64'd0;
         mat_ff[2] <= 64'h0001_0000_0000_0000;
         mat_ff[3] <= 64'd0;
         mat_ff[4] <= 64'd0;
         mat_ff[5] <= 64'h0001_0000_0000_0000;
         vw_ff <= 14'd1024;
         vh_ff <= 14'd768;
         v0_ff <= 1'b0;
      end else begin
         mat_ff <= mat_in;
         vw_ff <= vw_in;
         vh_ff <= vh_in;
         v0_ff <= accept;
      end
      wx_ff <= req_world_x;
      wy_ff <= req_world_y;
      wz_ff <= req_world_z;
   end

   wtsp_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clock(clock), .reset(reset), .in_valid(v0_ff),
      .in_x(wx_ff), .in_y(wy_ff), .in_z(wz_ff), .mat(mat_ff),
      .out_valid(dot_valid), .acc_x(acc_x), .acc_y(acc_y), .acc_w(acc_w)
   );

   wtsp_map #(.FRAC_BITS(FRAC_BITS)) u_map (
      .clock(clock), .reset(reset), .in_valid(dot_valid),
      .acc_x(acc_x), .acc_y(acc_y), .acc_w(acc_w),
      .size_x(vw_ff), .size_y(vh_ff),
      .ctl(map_ctl), .num_x(num_x), .num_y(num_y),
      .neg_x(neg_x), .neg_y(neg_y), .den(den)
   );

   wtsp_div #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_div_x (
      .clock(clock), .reset(reset), .in_ctl(map_ctl), .in_num(num_x),
      .in_den(den), .in_neg(neg_x),
      .out_ctl(dx_ctl), .out_quo(dx_quo), .out_neg(dx_neg), .out_ovf(dx_ovf)
   );

   wtsp_div #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_div_y (
      .clock(clock), .reset(reset), .in_ctl(map_ctl), .in_num(num_y),
      .in_den(den), .in_neg(neg_y),
      .out_ctl(dy_ctl), .out_quo(dy_quo), .out_neg(dy_neg), .out_ovf(dy_ovf)
   );

   // clamp to the signed pixel range, then keep the low output bits
   always_comb begin
      sat_x = dx_ovf || (dx_quo > (dx_neg ? LIM_NEG : LIM_POS));
      sat_y = dy_ovf || (dy_quo > (dy_neg ? LIM_NEG : LIM_POS));
      qx = sat_x ? (dx_neg ? LIM_NEG : LIM_POS) : dx_quo;
      qy = sat_y ? (dy_neg ? LIM_NEG : LIM_POS) : dy_quo;
      sx = dx_neg ? 32'd0 - 32'(qx) : 32'(qx);
      sy = dy_neg ? 32'd0 - 32'(qy) : 32'(qy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= dx_ctl.valid;
      end
      rdeg_ff <= dx_ctl.degen;
      rx_ff <= dx_ctl.degen ? '0 : sx[OUT_W-1:0];
      ry_ff <= dx_ctl.degen ? '0 : sy[OUT_W-1:0];
      rclip_ff <= !dx_ctl.degen && (sat_x || sat_y);
   end

   assign rsp_valid = rv_ff;
   assign rsp_screen_x = rx_ff;
   assign rsp_screen_y = ry_ff;
   assign rsp_degenerate = rdeg_ff;
   assign rsp_clipped = rclip_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result strobe without a matching request");
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      dx_ctl == dy_ctl)
      else $error("x and y divider lanes out of step");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("degenerate result with nonzero coordinates");
   a_degen_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_clipped)
      else $error("degenerate result flagged as clipped");

endmodule

@@ src/wtsp_dot.sv @@
// Matrix rows x, y, w times (x, y, z, 1): product stage, then sum stage.
// Depends on wtsp_pkg.
module wtsp_dot #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [31:0] in_x,
   input  logic signed [31:0] in_y,
   input  logic signed [31:0] in_z,
   input  logic [5:0][63:0] mat,
   output logic out_valid,
   output logic signed [wtsp_pkg::ACC_W-1:0] acc_x,
   output logic signed [wtsp_pkg::ACC_W-1:0] acc_y,
   output logic signed [wtsp_pkg::ACC_W-1:0] acc_w
);
   import wtsp_pkg::*;

   logic signed [63:0] prod_ff [3][3];
   logic signed [63:0] prod_in [3][3];
   logic signed [ACC_W-1:0] col3_ff [3];
   logic signed [ACC_W-1:0] col3_in [3];
   logic signed [ACC_W-1:0] sum_ff [3];
   logic signed [ACC_W-1:0] sum_in [3];
   logic v1_ff, v2_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(mat[2*r][31:0]) * in_x;
         prod_in[r][1] = $signed(mat[2*r][63:32]) * in_y;
         prod_in[r][2] = $signed(mat[2*r+1][31:0]) * in_z;
         col3_in[r] = ACC_W'($signed(mat[2*r+1][63:32])) <<< FRAC_BITS;
         sum_in[r] = ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1])
                   + ACC_W'(prod_ff[r][2]) + col3_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      prod_ff <= prod_in;
      col3_ff <= col3_in;
      sum_ff <= sum_in;
   end

   assign out_valid = v2_ff;
   assign acc_x = sum_ff[0];
   assign acc_y = sum_ff[1];
   assign acc_w = sum_ff[2];

endmodule

@@ src/wtsp_map.sv @@
// Viewport numerator and denominator: w + c, times size, plus w; |w| threshold.
// Three register stages. Depends on wtsp_pkg.
module wtsp_map #(
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [wtsp_pkg::ACC_W-1:0] acc_x,
   input  logic signed [wtsp_pkg::ACC_W-1:0] acc_y,
   input  logic signed [wtsp_pkg::ACC_W-1:0] acc_w,
   input  logic [wtsp_pkg::SIZE_W-1:0] size_x,
   input  logic [wtsp_pkg::SIZE_W-1:0] size_y,
   output wtsp_pkg::wtsp_ctl_type ctl,
   output logic [wtsp_pkg::NUM_W-1:0] num_x,
   output logic [wtsp_pkg::NUM_W-1:0] num_y,
   output logic neg_x,
   output logic neg_y,
   output logic [wtsp_pkg::DEN_W-1:0] den
);
   import wtsp_pkg::*;

   // ceil(2^(2F) / 100000)
   localparam logic [63:0] THR64 = ((64'd1 << (2*FRAC_BITS)) + 64'd99999) / 64'd100000;
   localparam logic [ACC_W-1:0] THR = ACC_W'(THR64);

   wtsp_ctl_type ca_ff, cb_ff, cc_ff;
   logic signed [ACC_W:0] ax_ff, ay_ff;
   logic signed [ACC_W-1:0] wa_ff, wb_ff;
   logic [ACC_W-1:0] absw_in, absa_ff, absb_ff;
   logic signed [NUM_W-1:0] mx_ff, my_ff, mx_in, my_in, nx, ny;
   logic [NUM_W-1:0] numx_ff, numy_ff;
   logic negx_ff, negy_ff;
   logic [DEN_W-1:0] den_ff;

   always_comb begin
      absw_in = acc_w[ACC_W-1] ? ACC_W'(-acc_w) : ACC_W'(acc_w);
      mx_in = NUM_W'(ax_ff) * NUM_W'($signed({1'b0, size_x}));
      my_in = NUM_W'(ay_ff) * NUM_W'($signed({1'b0, size_y}));
      nx = mx_ff + NUM_W'(wb_ff);
      ny = my_ff + NUM_W'(wb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
         cc_ff <= '0;
      end else begin
         ca_ff <= '{valid: in_valid, degen: absw_in < THR};
         cb_ff <= ca_ff;
         cc_ff <= cb_ff;
      end
      ax_ff <= (ACC_W+1)'(acc_w) + (ACC_W+1)'(acc_x);
      ay_ff <= (ACC_W+1)'(acc_w) + (ACC_W+1)'(acc_y);
      wa_ff <= acc_w;
      absa_ff <= absw_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      wb_ff <= wa_ff;
      absb_ff <= absa_ff;
      // denominator 2w carries the sign of w
      negx_ff <= nx[NUM_W-1] ^ wb_ff[ACC_W-1];
      negy_ff <= ny[NUM_W-1] ^ wb_ff[ACC_W-1];
      numx_ff <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      numy_ff <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      den_ff <= {absb_ff, 1'b0};
   end

   assign ctl = cc_ff;
   assign num_x = numx_ff;
   assign num_y = numy_ff;
   assign neg_x = negx_ff;
   assign neg_y = negy_ff;
   assign den = den_ff;

endmodule

@@ src/wtsp_div.sv @@
// Restoring divider, one quotient bit per register stage, PIXEL_WIDTH stages.
// Flags quotients of 2^PIXEL_WIDTH or more as overflow. Depends on wtsp_pkg.
module wtsp_div #(
   parameter int PIXEL_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  wtsp_pkg::wtsp_ctl_type in_ctl,
   input  logic [wtsp_pkg::NUM_W-1:0] in_num,
   input  logic [wtsp_pkg::DEN_W-1:0] in_den,
   input  logic in_neg,
   output wtsp_pkg::wtsp_ctl_type out_ctl,
   output logic [PIXEL_WIDTH-1:0] out_quo,
   output logic out_neg,
   output logic out_ovf
);
   import wtsp_pkg::*;

   localparam int CW = NUM_W + PIXEL_WIDTH;

   wtsp_ctl_type ctl_ff [1:PIXEL_WIDTH];
   logic [NUM_W-1:0] rem_ff [1:PIXEL_WIDTH];
   logic [DEN_W-1:0] den_ff [1:PIXEL_WIDTH];
   logic [PIXEL_WIDTH-1:0] quo_ff [1:PIXEL_WIDTH];
   logic neg_ff [1:PIXEL_WIDTH];
   logic ovf_ff [1:PIXEL_WIDTH];

   for (genvar k = 0; k < PIXEL_WIDTH; k++) begin : g_stage
      wtsp_ctl_type c_src;
      logic [NUM_W-1:0] r_src;
      logic [DEN_W-1:0] d_src;
      logic [PIXEL_WIDTH-1:0] q_src;
      logic n_src, o_src, take;
      logic [CW-1:0] shd;

      if (k == 0) begin : g_first
         assign c_src = in_ctl;
         assign r_src = in_num;
         assign d_src = in_den;
         assign q_src = '0;
         assign n_src = in_neg;
         assign o_src = CW'(in_num) >= (CW'(in_den) << PIXEL_WIDTH);
      end else begin : g_next
         assign c_src = ctl_ff[k];
         assign r_src = rem_ff[k];
         assign d_src = den_ff[k];
         assign q_src = quo_ff[k];
         assign n_src = neg_ff[k];
         assign o_src = ovf_ff[k];
      end

      assign shd = CW'(d_src) << (PIXEL_WIDTH - 1 - k);
      assign take = CW'(r_src) >= shd;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1] <= '0;
         end else begin
            ctl_ff[k+1] <= c_src;
         end
         rem_ff[k+1] <= take ? NUM_W'(CW'(r_src) - shd) : r_src;
         den_ff[k+1] <= d_src;
         quo_ff[k+1] <= {q_src[PIXEL_WIDTH-2:0], take};
         neg_ff[k+1] <= n_src;
         ovf_ff[k+1] <= o_src;
      end
   end

   assign out_ctl = ctl_ff[PIXEL_WIDTH];
   assign out_quo = quo_ff[PIXEL_WIDTH];
   assign out_neg = neg_ff[PIXEL_WIDTH];
   assign out_ovf = ovf_ff[PIXEL_WIDTH];

endmodule

@@ tb/sv/world_to_screen_projection_core_tb.sv @@
// Self-checking testbench for world_to_screen_projection_core: directed and random points,
// matrix and viewport settings, with a built-in projection predictor. Depends on wtsp_pkg.
`timescale 1ns / 1ps

module world_to_screen_projection_core_tb;
   import wtsp_pkg::*;

   localparam logic [IDX_W-1:0] CSR_UNUSED_IDX = 4'd11;
   localparam logic signed [127:0] ONE_Q = 128'sd65536;
   localparam logic [127:0] DEGEN_LIMIT = 128'd42950;   // ceil(2^32 / 100000)
   localparam int LATENCY = 16 + 7;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [OUT_W-1:0] sx;
      logic signed [OUT_W-1:0] sy;
      logic degen;
      logic clip;
   } pixel_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [31:0] req_world_x, req_world_y, req_world_z;
   logic rsp_valid;
   logic signed [OUT_W-1:0] rsp_screen_x, rsp_screen_y;
   logic rsp_degenerate, rsp_clipped;
   logic csr_valid;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index;
   logic [63:0] csr_wdata;

   logic [63:0] matrix_regs [0:7];
   pixel_type pending_pixels [$];
   int gap_pct;
   int n_points, n_pixels, n_degen, n_clip, n_mismatch;
   int cycle_count;

   world_to_screen_projection_core dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_world_x(req_world_x), .req_world_y(req_world_y), .req_world_z(req_world_z),
      .rsp_valid(rsp_valid), .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
      .rsp_degenerate(rsp_degenerate), .rsp_clipped(rsp_clipped),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
                  pending_pixels.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [127:0] row_sum(int r, logic signed [31:0] x,
                                                   logic signed [31:0] y,
                                                   logic signed [31:0] z);
      logic [63:0] a, b;
      logic signed [127:0] acc;
      a = matrix_regs[2*r];
      b = matrix_regs[2*r+1];
      acc = $signed(a[31:0]) * x;
      acc = acc + $signed(a[63:32]) * y;
      acc = acc + $signed(b[31:0]) * z;
      acc = acc + $signed(b[63:32]) * ONE_Q;
      return acc;
   endfunction

   // pixel = trunc(((w + c) * size + w) / (2w)), clamped to 16-bit signed
   function automatic logic [OUT_W-1:0] axis_to_pixel(logic signed [127:0] c,
                                                      logic signed [127:0] w,
                                                      logic [SIZE_W-1:0] size,
                                                      inout logic clip);
      logic signed [127:0] num, den;
      logic [127:0] num_mag, den_mag, q, lim;
      logic neg;
      num = (w + c) * $signed({114'b0, size}) + w;
      den = w + w;
      neg = num[127] ^ den[127];
      num_mag = num[127] ? -num : num;
      den_mag = den[127] ? -den : den;
      q = num_mag / den_mag;
      lim = neg ? 128'd32768 : 128'd32767;
      if (q > lim) begin
         clip = 1'b1;
         q = lim;
      end
      if (neg)
         q = -q;
      return q[OUT_W-1:0];
   endfunction

   function automatic pixel_type project_point(logic signed [31:0] x, logic signed [31:0] y,
                                               logic signed [31:0] z);
      logic signed [127:0] xs, ys, ws;
      logic [127:0] w_mag;
      logic clip;
      pixel_type p;
      xs = row_sum(0, x, y, z);
      ys = row_sum(1, x, y, z);
      ws = row_sum(2, x, y, z);
      w_mag = ws[127] ? -ws : ws;
      clip = 1'b0;
      p = '0;
      if (w_mag < DEGEN_LIMIT) begin
         p.degen = 1'b1;
         return p;
      end
      p.sx = axis_to_pixel(xs, ws, matrix_regs[6][SIZE_W-1:0], clip);
      p.sy = axis_to_pixel(ys, ws, matrix_regs[7][SIZE_W-1:0], clip);
      p.clip = clip;
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid) begin
         n_pixels++;
         if (pending_pixels.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected pixel x=%0d y=%0d", rsp_screen_x, rsp_screen_y);
         end else begin
            want = pending_pixels[0];
            pending_pixels.delete(0);
            if (rsp_screen_x !== want.sx || rsp_screen_y !== want.sy ||
                rsp_degenerate !== want.degen || rsp_clipped !== want.clip) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("pixel mismatch: want x=%0d y=%0d dg=%0b cl=%0b, got %0d %0d %0b %0b",
                           want.sx, want.sy, want.degen, want.clip, rsp_screen_x,
                           rsp_screen_y, rsp_degenerate, rsp_clipped);
            end
            if (want.degen) n_degen++;
            if (want.clip) n_clip++;
         end
      end
   end

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
      if ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_world_x <= x;
      req_world_y <= y;
      req_world_z <= z;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(project_point(x, y, z));
      n_points++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < 8)
         matrix_regs[idx] = (idx >= CSR_VIEW_WIDTH) ? (data & 64'h3FFF) : data;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] small_q();
      return $urandom_range(0, 262143) - 131072;   // about +-2.0
   endfunction

   task automatic load_random_matrix();
      write_csr(CSR_MAT_X_01, {small_q(), small_q()});
      write_csr(CSR_MAT_X_23, {small_q(), small_q()});
      write_csr(CSR_MAT_Y_01, {small_q(), small_q()});
      write_csr(CSR_MAT_Y_23, {small_q(), small_q()});
      write_csr(CSR_MAT_W_01, {small_q() >>> 3, small_q() >>> 3});
      write_csr(CSR_MAT_W_23, {32'sh0001_0000 + (small_q() >>> 2), small_q() >>> 3});
      write_csr(CSR_VIEW_WIDTH, 64'($urandom_range(1, 8192)));
      write_csr(CSR_VIEW_HEIGHT, 64'($urandom_range(1, 8192)));
   endtask

   task automatic test_reset_defaults();
      send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(32'sh0, 32'sh0, 32'sh0);
      send_point(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
      wait_idle();
   endtask

   // w threshold just below and at 1e-5, and an all-zero w row
   task automatic test_degenerate_w();
      write_csr(CSR_MAT_W_01, 64'h0000_0000_0000_0001);
      write_csr(CSR_MAT_W_23, 64'h0);
      send_point(32'sd42949, 32'sh0, 32'sh0);
      send_point(32'sd42950, 32'sh0, 32'sh0);
      send_point(-32'sd42949, 32'sh1234, 32'sh0);
      send_point(-32'sd42950, 32'sh1234, 32'sh0);
      wait_idle();
      write_csr(CSR_MAT_W_01, 64'h0);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      wait_idle();
   endtask

   // extreme entries, zero and out-of-range viewport sizes, ignored index
   task automatic test_extreme_registers();
      write_csr(CSR_MAT_X_01, 64'h8000_0000_7FFF_FFFF);
      write_csr(CSR_MAT_X_23, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_MAT_Y_01, 64'h7FFF_FFFF_8000_0000);
      write_csr(CSR_MAT_Y_23, 64'h8000_0000_8000_0000);
      write_csr(CSR_MAT_W_01, 64'h0000_0001_FFFF_FFFF);
      write_csr(CSR_MAT_W_23, 64'h8000_0000_0000_0000);
      write_csr(CSR_VIEW_WIDTH, 64'd0);
      write_csr(CSR_VIEW_HEIGHT, 64'd8192);
      send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1);
      send_point(32'sh1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      wait_idle();
      write_csr(CSR_MAT_W_23, 64'h7FFF_FFFF_0000_0000);
      write_csr(CSR_VIEW_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF);
      write_csr(CSR_VIEW_HEIGHT, 64'd1);
      write_csr(CSR_UNUSED_IDX, 64'h0);
      send_point(32'sh0, 32'sh0, 32'sh0);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      wait_idle();
   endtask

   task automatic test_random_points(int count);
      logic signed [31:0] x, y, z;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            wait_idle();
            load_random_matrix();
         end
         if ($urandom_range(99) < 70) begin
            x = small_q() <<< 1;
            y = small_q() <<< 1;
            z = small_q() <<< 1;
         end else begin
            x = $urandom;
            y = $urandom;
            z = $urandom;
         end
         send_point(x, y, z);
         if (i == count / 2)
            wait_idle();   // hold off until the pipe has emptied
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_world_x = '0;
      req_world_y = '0;
      req_world_z = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      gap_pct = 0;
      matrix_regs[0] = 64'd4294967296;
      matrix_regs[1] = 64'd0;
      matrix_regs[2] = 64'd281474976710656;
      matrix_regs[3] = 64'd0;
      matrix_regs[4] = 64'd0;
      matrix_regs[5] = 64'd281474976710656;
      matrix_regs[6] = 64'd1024;
      matrix_regs[7] = 64'd768;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_degenerate_w();
      test_extreme_registers();
      gap_pct = 18;
      test_random_points(260);
      gap_pct = 69;
      test_random_points(260);
      gap_pct = 0;
      test_random_points(280);

      $display("%0d points projected, %0d pixels checked (%0d degenerate, %0d clipped)",
               n_points, n_pixels, n_degen, n_clip);
      $display("covered reset, extreme and random matrices, size 0..8192, idle gaps");
      if (n_mismatch == 0 && pending_pixels.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ sim.f @@
src/wtsp_pkg.sv
src/wtsp_dot.sv
src/wtsp_map.sv
src/wtsp_div.sv
src/world_to_screen_projection_core.sv
tb/sv/world_to_screen_projection_core_tb.sv
